FILE: rtl/brc_pkg.sv
package brc_pkg;

    localparam int XW    = 32;
    localparam int PASSW = 6;
    localparam int TOLW  = 31;

    localparam logic [TOLW-1:0]   TOL_RESET = TOLW'(66);
    localparam logic [2*XW-1:0]   SQ_THREE  = 64'h0000_0003_0000_0000;
    localparam logic signed [XW:0] ONE_Q16  = 33'sd65536;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic signed [XW-1:0] x_low;
        logic signed [XW-1:0] x_high;
    } t_in;

    typedef struct packed {
        logic signed [XW-1:0] root;
        logic [PASSW-1:0]     passes;
        logic                 status;
    } t_out;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

endpackage

FILE: rtl/bisection_root_cubic_unit.sv
// Bisection root finder for x^3 + x^2 - 3x - 3 on a signed Q16.16 bracket.
// A bad bracket is reported from CHK_HI once both endpoints have been squared.
// One transaction at a time: the next one is taken only once the result is
// posted, and a stalled output holds the unit until the result leaves. Each
// pass runs midpoint, square on the shared 32x32 multiplier, and sign compare.
// Synchronous active-low reset clears the sequencer, output valid, and sets
// the tolerance to 66.
module bisection_root_cubic_unit
    import brc_pkg::*;
#(
    parameter int MAX_PASSES = 39
)
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [TOLW-1:0] i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in             i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out            o_out_data
);

    localparam int PCW = $clog2(MAX_PASSES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL_LO  = 3'd1;
    localparam logic [2:0] S_MUL_HI  = 3'd2;
    localparam logic [2:0] S_CHK_HI  = 3'd3;
    localparam logic [2:0] S_MID     = 3'd4;
    localparam logic [2:0] S_MUL_MID = 3'd5;
    localparam logic [2:0] S_CHK_MID = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [TOLW-1:0]      r_tol;
    logic signed [XW-1:0] r_lo, n_lo;
    logic signed [XW-1:0] r_hi, n_hi;
    logic signed [XW-1:0] r_mid, n_mid;
    logic [XW-1:0]        r_width, n_width;
    logic [PCW-1:0]       r_passes, n_passes;
    t_sign                r_sign_lo, n_sign_lo;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic                 w_load;
    logic signed [XW-1:0] w_x;
    t_sign                w_sign;
    logic                 w_out_free;
    logic signed [XW:0]   w_sum;
    logic signed [XW:0]   w_diff;
    logic                 w_stop;

    brc_sign_unit u_sign (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_x    (w_x),
        .o_sign (w_sign)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_sum  = {r_lo[XW-1], r_lo} + {r_hi[XW-1], r_hi};
    assign w_diff = {r_hi[XW-1], r_hi} - {r_lo[XW-1], r_lo};
    assign w_stop = ({1'b0, r_tol} >= r_width) || (r_passes == PCW'(MAX_PASSES - 1));

    always_comb begin
        w_load = 1'b0;
        w_x    = r_mid;
        unique case (r_state)
            S_MUL_LO:  begin w_load = 1'b1; w_x = r_lo; end
            S_MUL_HI:  begin w_load = 1'b1; w_x = r_hi; end
            S_MUL_MID: begin w_load = 1'b1; w_x = r_mid; end
            default:   begin w_load = 1'b0; w_x = r_mid; end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_width     = r_width;
        n_passes    = r_passes;
        n_sign_lo   = r_sign_lo;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lo     = i_in_data.x_low;
                    n_hi     = i_in_data.x_high;
                    n_passes = '0;
                    n_state  = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_sign_lo = w_sign;
                n_state   = S_CHK_HI;
            end
            S_CHK_HI: begin
                if (!r_sign_lo.zero && !w_sign.zero && (r_sign_lo.neg == w_sign.neg)) begin
                    if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_out.root    = '0;
                        n_out.passes  = '0;
                        n_out.status  = STATUS_BAD;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_state = S_MID;
                end
            end
            S_MID: begin
                n_mid   = w_sum[XW:1];
                n_width = w_diff[XW] ? XW'(-w_diff) : w_diff[XW-1:0];
                n_state = S_MUL_MID;
            end
            S_MUL_MID: begin
                n_state = S_CHK_MID;
            end
            S_CHK_MID: begin
                if (!w_stop || w_out_free) begin
                    if (!r_sign_lo.zero && !w_sign.zero && (r_sign_lo.neg != w_sign.neg)) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo      = r_mid;
                        n_sign_lo = w_sign;
                    end
                    n_passes = r_passes + PCW'(1);
                    if (w_stop) begin
                        n_out_valid  = 1'b1;
                        n_out.root   = r_mid;
                        n_out.passes = PASSW'(n_passes);
                        n_out.status = STATUS_OK;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_MID;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_width   <= n_width;
        r_passes  <= n_passes;
        r_sign_lo <= n_sign_lo;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/brc_sign_unit.sv
module brc_sign_unit
    import brc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic signed [XW-1:0] i_x,
    output t_sign                o_sign
);

    logic [XW-1:0]        w_mag;
    logic signed [XW:0]   w_a;
    logic [2*XW-1:0]      r_sq;
    logic                 r_a_neg;
    logic                 r_a_zero;
    logic                 w_b_neg;
    logic                 w_b_zero;

    // p(x) = (x + 1)(x^2 - 3)
    assign w_mag = i_x[XW-1] ? (~i_x + XW'(1)) : i_x;
    assign w_a   = {i_x[XW-1], i_x} + ONE_Q16;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq     <= w_mag * w_mag;
            r_a_neg  <= w_a[XW];
            r_a_zero <= (w_a == '0);
        end
    end

    assign w_b_zero = (r_sq == SQ_THREE);
    assign w_b_neg  = (r_sq < SQ_THREE);

    assign o_sign.zero = r_a_zero | w_b_zero;
    assign o_sign.neg  = r_a_neg ^ w_b_neg;

endmodule

FILE: tb/tb.sv
module tb;
    import brc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BISECT_PASSES = 39;
    localparam int  RUN_LIMIT     = 3_000_000;
    localparam int  SETTLE_CYCLES = 130;
    localparam int  RANDOM_ITEMS  = 1650;
    localparam int  N_PHASES      = 8;
    localparam int  ROOT_NEG_SQRT3 = -113512;
    localparam int  ROOT_NEG_ONE   = -65536;
    localparam int  ROOT_POS_SQRT3 = 113512;
    localparam logic [XW-1:0] X_MIN = 32'h8000_0000;
    localparam logic [XW-1:0] X_MAX = 32'h7fff_ffff;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [TOLW-1:0] i_cfg_wdata = '0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in             i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out            o_out_data;

    t_in             bracket_q[$];
    t_out            root_q[$];
    logic [TOLW-1:0] tol_model = TOL_RESET;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    bit              hold_sender = 1'b0;
    bit              in_taken = 1'b0;
    int              n_err = 0;
    int              n_checked = 0;
    int              n_bad = 0;
    int              n_capped = 0;
    int              n_tol_writes = 0;
    int              cycle_cnt = 0;

    bisection_root_cubic_unit #(
        .MAX_PASSES(BISECT_PASSES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // p(x) = (x + 1)(x^2 - 3), sign taken from both factors exactly
    function automatic int cubic_sign_of(longint x);
        longint          a;
        longint unsigned m;
        longint unsigned sq;
        int              sa;
        int              sb;
        a  = x + longint'(ONE_Q16);
        m  = (x < 0) ? -x : x;
        sq = m * m;
        sa = int'(a > 0) - int'(a < 0);
        sb = int'(sq > SQ_THREE) - int'(sq < SQ_THREE);
        return sa * sb;
    endfunction

    function automatic t_out solve_bracket(t_in b, logic [TOLW-1:0] tol);
        longint          lo;
        longint          hi;
        longint          s;
        longint          d;
        longint          mid;
        longint unsigned width;
        int              steps;
        t_out            r;
        lo = longint'($signed(b.x_low));
        hi = longint'($signed(b.x_high));
        r  = '0;
        if (cubic_sign_of(lo) * cubic_sign_of(hi) > 0) begin
            r.status = STATUS_BAD;
            return r;
        end
        steps = 0;
        mid   = 0;
        do begin
            s     = lo + hi;
            d     = hi - lo;
            mid   = s >>> 1;
            width = (d < 0) ? -d : d;
            if (cubic_sign_of(lo) * cubic_sign_of(mid) < 0) begin
                hi = mid;
            end else begin
                lo = mid;
            end
            steps++;
        end while (width > tol && steps < BISECT_PASSES);
        r.root   = mid[XW-1:0];
        r.passes = steps[PASSW-1:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    function automatic t_in random_bracket();
        longint c;
        longint lo;
        longint hi;
        longint t;
        int     kind;
        int     sh;
        t_in    b;
        kind = $urandom_range(99);
        case ($urandom_range(2))
            0: c = ROOT_NEG_SQRT3;
            1: c = ROOT_NEG_ONE;
            default: c = ROOT_POS_SQRT3;
        endcase
        if (kind < 55) begin
            sh = $urandom_range(30);
            lo = c - longint'($urandom & ((32'd1 << sh) - 1));
            sh = $urandom_range(30);
            hi = c + longint'($urandom & ((32'd1 << sh) - 1));
        end else if (kind < 70) begin
            lo = longint'($signed($urandom));
            hi = longint'($signed($urandom));
        end else if (kind < 80) begin
            lo = ROOT_NEG_ONE;
            hi = longint'($signed($urandom));
        end else begin
            lo = c - $urandom_range(200);
            hi = c + $urandom_range(200);
        end
        if ($urandom_range(1)) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        b.x_low  = lo[XW-1:0];
        b.x_high = hi[XW-1:0];
        return b;
    endfunction

    task automatic push_bracket(logic [XW-1:0] lo, logic [XW-1:0] hi);
        t_in b;
        b.x_low  = lo;
        b.x_high = hi;
        bracket_q.push_back(b);
    endtask

    task automatic write_tolerance(logic [TOLW-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tol_model = v;
        n_tol_writes++;
    endtask

    task automatic wait_drained();
        while (bracket_q.size() != 0 || i_in_valid || root_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver: new transaction offered at the falling edge once the last one was taken
    always @(negedge i_clk) begin : drive
        t_in nxt;
        if (i_rst_n) begin
            if (in_taken || !i_in_valid) begin
                in_taken = 1'b0;
                if (!hold_sender && bracket_q.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = bracket_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= nxt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out exp_r;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                root_q.push_back(solve_bracket(i_in_data, tol_model));
            end
            if (o_out_valid && !i_out_stall) begin
                if (root_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("unexpected result: root %0d passes %0d status %0d",
                                 o_out_data.root, o_out_data.passes, o_out_data.status);
                    end
                end else begin
                    exp_r = root_q.pop_front();
                    n_checked++;
                    if (exp_r.status == STATUS_BAD) n_bad++;
                    if (exp_r.passes == BISECT_PASSES) n_capped++;
                    if (o_out_data.root !== exp_r.root || o_out_data.passes !== exp_r.passes ||
                        o_out_data.status !== exp_r.status) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     exp_r.root, exp_r.passes, exp_r.status, o_out_data.root,
                                     o_out_data.passes, o_out_data.status);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("bisection_root_cubic_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TOLW-1:0] tols[N_PHASES];
        int              sidle[N_PHASES];
        int              rstall[N_PHASES];
        int              per_phase;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed brackets at reset tolerance
        push_bracket(X_MIN, X_MAX);
        push_bracket(X_MAX, X_MIN);
        push_bracket(0, 0);
        push_bracket(X_MIN, X_MIN);
        push_bracket(X_MAX, X_MAX);
        push_bracket(ROOT_NEG_ONE, ROOT_NEG_ONE);
        push_bracket(ROOT_NEG_ONE, 5 * 65536);
        push_bracket(0, ROOT_NEG_ONE);
        push_bracket(0, 2 * 65536);
        push_bracket(2 * 65536, 0);
        push_bracket(-98304, -32768);
        push_bracket(-2 * 65536, -98304);
        push_bracket(-2 * 65536, 0);
        push_bracket(113511, 113512);
        push_bracket(-113512, -113511);
        push_bracket(1, -1);
        push_bracket(-1, X_MAX);
        push_bracket(X_MIN, ROOT_NEG_ONE);
        push_bracket(X_MAX, 113511);
        push_bracket(X_MIN, 113511);
        wait_drained();
        repeat (8) @(posedge i_clk);

        tols[0] = TOL_RESET;        sidle[0] = 0;  rstall[0] = 0;
        tols[1] = '0;               sidle[1] = 79; rstall[1] = 0;
        tols[2] = 31'h7fff_ffff;    sidle[2] = 0;  rstall[2] = 79;
        tols[3] = TOLW'($urandom_range(4096)); sidle[3] = 18; rstall[3] = 18;
        tols[4] = 31'd65536;        sidle[4] = 0;  rstall[4] = 0;
        tols[5] = TOLW'($urandom_range(1 << 20)); sidle[5] = 79; rstall[5] = 0;
        tols[6] = 31'd1;            sidle[6] = 0;  rstall[6] = 79;
        tols[7] = TOLW'($urandom); sidle[7] = 18; rstall[7] = 18;
        per_phase = RANDOM_ITEMS / N_PHASES;

        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct  = sidle[p];
            recv_stall_pct = rstall[p];
            write_tolerance(tols[p]);
            for (int k = 0; k < per_phase; k++) bracket_q.push_back(random_bracket());
            if (p == 4) begin
                while (bracket_q.size() > per_phase / 2) @(posedge i_clk);
                hold_sender = 1'b1;
                while (i_in_valid || root_q.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
            repeat (8) @(posedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (root_q.size() != 0) begin
            $display("%0d expected results never arrived", root_q.size());
            n_err += root_q.size();
        end
        $display("checked %0d results over %0d tolerance settings",
                 n_checked, n_tol_writes);
        $display("%0d bad brackets, %0d hit the pass cap, mismatches: %0d",
                 n_bad, n_capped, n_err);
        if (n_err == 0) begin
            $display("bisection_root_cubic_unit test passed");
        end else begin
            $display("bisection_root_cubic_unit test failed");
        end
        $finish;
    end

endmodule

FILE: bisection_root_cubic_unit.f
rtl/brc_pkg.sv
rtl/brc_sign_unit.sv
rtl/bisection_root_cubic_unit.sv
tb/tb.sv
